// ----- rtl/jsu_pkg.sv -----
// Shared types and constants for the JSON string unescape block.
`default_nettype none

package jsu_pkg;

	localparam int MAX_RES   = 7;
	localparam int RES_IDX_W = 3;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_END_OK  = 2'd1;
	localparam logic [1:0] KIND_END_ERR = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       last;
	} ent_t;

	typedef struct packed {
		ent_t [MAX_RES-1:0]   ent;
		logic [RES_IDX_W-1:0] cnt;
	} rec_t;

endpackage

`default_nettype wire

// ----- rtl/jsu_front.sv -----
// Front end: escape decoding, UTF-8 encoding and BOM filtering into result records.
`default_nettype none

module jsu_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic [7:0]     in_byte,
	input  wire logic           token_end,
	input  wire logic           cfg_we,
	input  wire logic           cfg_strip,
	output jsu_pkg::rec_t       rec,
	output logic                push
);

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_ESC  = 4'd1,
		PH_H1   = 4'd2,
		PH_H2   = 4'd3,
		PH_H3   = 4'd4,
		PH_H4   = 4'd5,
		PH_BSL  = 4'd6,
		PH_U    = 4'd7,
		PH_L1   = 4'd8,
		PH_L2   = 4'd9,
		PH_L3   = 4'd10,
		PH_L4   = 4'd11
	} phase_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	localparam logic [15:0] SUR_HI_MIN = 16'hD800;
	localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
	localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
	localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;
	localparam logic [20:0] CP_SUPP    = 21'h10000;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c inside {[8'h30:8'h39]})
			r = {1'b1, c[3:0]};
		else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

	function automatic logic [7:0] bom_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = 8'hEF;
			2'd1: r = 8'hBB;
			default: r = 8'hBF;
		endcase
		return r;
	endfunction

	function automatic jsu_pkg::ent_t mk_ent(input logic [7:0] d, input logic [1:0] k,
		input logic l);
		jsu_pkg::ent_t e;
		e.data = d;
		e.kind = k;
		e.last = l;
		return e;
	endfunction

	phase_t      phase_q, phase_d;
	logic [15:0] acc_q, acc_d, acc_x;
	logic [9:0]  hs_q, hs_d;
	logic [1:0]  hold_cnt_q, hc;
	logic        prefix_q, pc;
	logic        err_q, err;
	logic        strip_q;

	logic        ok, enc;
	logic [4:0]  hx;
	logic [20:0] cp;
	logic [2:0]  nd;
	logic [7:0]  dat [4];
	logic [7:0]  b;
	logic [jsu_pkg::RES_IDX_W-1:0] cnt;

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		hs_d    = hs_q;
		ok      = 1'b1;
		enc     = 1'b0;
		nd      = 3'd0;
		cp      = '0;
		for (int i = 0; i < 4; i++)
			dat[i] = '0;
		hx      = hex_digit(in_byte);
		acc_x   = {acc_q[11:0], hx[3:0]};
		if (!err_q) begin
			case (phase_q)
				PH_IDLE: begin
					if (in_byte == CH_BSL) begin
						phase_d = PH_ESC;
					end else begin
						nd     = 3'd1;
						dat[0] = in_byte;
					end
				end
				PH_ESC: begin
					phase_d = PH_IDLE;
					nd      = 3'd1;
					case (in_byte)
						CH_QUOTE: dat[0] = CH_QUOTE;
						CH_BSL:   dat[0] = CH_BSL;
						CH_SLASH: dat[0] = CH_SLASH;
						CH_B:     dat[0] = 8'h08;
						CH_F:     dat[0] = 8'h0C;
						CH_N:     dat[0] = 8'h0A;
						CH_R:     dat[0] = 8'h0D;
						CH_T:     dat[0] = 8'h09;
						CH_U: begin
							nd      = 3'd0;
							phase_d = PH_H1;
							acc_d   = '0;
						end
						default: begin
							nd = 3'd0;
							ok = 1'b0;
						end
					endcase
				end
				PH_BSL: begin
					if (in_byte != CH_BSL)
						ok = 1'b0;
					else
						phase_d = PH_U;
				end
				PH_U: begin
					if (in_byte != CH_U) begin
						ok = 1'b0;
					end else begin
						phase_d = PH_L1;
						acc_d   = '0;
					end
				end
				PH_H1, PH_H2, PH_H3, PH_L1, PH_L2, PH_L3: begin
					if (!hx[4]) begin
						ok = 1'b0;
					end else begin
						acc_d   = acc_x;
						phase_d = phase_t'(phase_q + 4'd1);
					end
				end
				PH_H4: begin
					if (!hx[4]) begin
						ok = 1'b0;
					end else begin
						acc_d   = acc_x;
						phase_d = PH_IDLE;
						if (acc_x inside {[SUR_HI_MIN:SUR_HI_MAX]}) begin
							hs_d    = acc_x[9:0];
							phase_d = PH_BSL;
						end else if (acc_x inside {[SUR_LO_MIN:SUR_LO_MAX]}) begin
							ok = 1'b0;
						end else begin
							enc = 1'b1;
							cp  = {5'd0, acc_x};
						end
					end
				end
				PH_L4: begin
					if (!hx[4]) begin
						ok = 1'b0;
					end else begin
						acc_d   = acc_x;
						phase_d = PH_IDLE;
						if (acc_x inside {[SUR_LO_MIN:SUR_LO_MAX]}) begin
							enc = 1'b1;
							cp  = CP_SUPP + {1'b0, hs_q, acc_x[9:0]};
						end else begin
							ok = 1'b0;
						end
					end
				end
				default: ok = 1'b0;
			endcase
		end
		if (enc) begin
			if (cp < 21'h80) begin
				nd     = 3'd1;
				dat[0] = cp[7:0];
			end else if (cp < 21'h800) begin
				nd     = 3'd2;
				dat[0] = 8'hC0 | {3'd0, cp[10:6]};
				dat[1] = 8'h80 | {2'd0, cp[5:0]};
			end else if (cp < 21'h10000) begin
				nd     = 3'd3;
				dat[0] = 8'hE0 | {4'd0, cp[15:12]};
				dat[1] = 8'h80 | {2'd0, cp[11:6]};
				dat[2] = 8'h80 | {2'd0, cp[5:0]};
			end else begin
				nd     = 3'd4;
				dat[0] = 8'hF0 | {5'd0, cp[20:18]};
				dat[1] = 8'h80 | {2'd0, cp[17:12]};
				dat[2] = 8'h80 | {2'd0, cp[11:6]};
				dat[3] = 8'h80 | {2'd0, cp[5:0]};
			end
		end
	end

	always_comb begin
		rec.ent = '0;
		cnt     = '0;
		hc      = hold_cnt_q;
		pc      = prefix_q;
		err     = err_q;
		b       = '0;
		if (!err_q) begin
			if (!ok) begin
				hc           = 2'd0;
				rec.ent[cnt] = mk_ent(8'd0, jsu_pkg::KIND_END_ERR, 1'b1);
				cnt          = cnt + 3'd1;
				err          = 1'b1;
			end else begin
				for (int i = 0; i < 4; i++) begin
					if (3'(i) < nd) begin
						b = dat[i];
						if (!pc && strip_q && hc != 2'd3 && b == bom_byte(hc)) begin
							hc = hc + 2'd1;
							if (hc == 2'd3) begin
								hc = 2'd0;
								pc = 1'b1;
							end
						end else begin
							for (int j = 0; j < 3; j++) begin
								if (2'(j) < hc) begin
									rec.ent[cnt] = mk_ent(bom_byte(2'(j)),
										jsu_pkg::KIND_DATA, 1'b0);
									cnt = cnt + 3'd1;
								end
							end
							hc           = 2'd0;
							pc           = 1'b1;
							rec.ent[cnt] = mk_ent(b, jsu_pkg::KIND_DATA, 1'b0);
							cnt          = cnt + 3'd1;
						end
					end
				end
			end
		end
		if (token_end && !err) begin
			if (phase_d != PH_IDLE) begin
				rec.ent[cnt] = mk_ent(8'd0, jsu_pkg::KIND_END_ERR, 1'b1);
				cnt          = cnt + 3'd1;
			end else begin
				for (int j = 0; j < 3; j++) begin
					if (2'(j) < hc) begin
						rec.ent[cnt] = mk_ent(bom_byte(2'(j)), jsu_pkg::KIND_DATA, 1'b0);
						cnt          = cnt + 3'd1;
					end
				end
				rec.ent[cnt] = mk_ent(8'd0, jsu_pkg::KIND_END_OK, 1'b1);
				cnt          = cnt + 3'd1;
			end
		end
		rec.cnt = cnt;
	end

	assign push = accept && (rec.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			acc_q      <= '0;
			hs_q       <= '0;
			hold_cnt_q <= '0;
			prefix_q   <= 1'b0;
			err_q      <= 1'b0;
			strip_q    <= 1'b1;
		end else begin
			if (cfg_we)
				strip_q <= cfg_strip;
			if (accept) begin
				if (token_end) begin
					phase_q    <= PH_IDLE;
					acc_q      <= '0;
					hs_q       <= '0;
					hold_cnt_q <= '0;
					prefix_q   <= 1'b0;
					err_q      <= 1'b0;
				end else begin
					phase_q    <= phase_d;
					acc_q      <= acc_d;
					hs_q       <= hs_d;
					hold_cnt_q <= hc;
					prefix_q   <= pc;
					err_q      <= err;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_end_has_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && token_end && !err_q |-> push && rec.ent[rec.cnt - 3'd1].last)
		else $error("token end without a final result");
	a_hold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hold_cnt_q != 2'd3)
		else $error("BOM hold count out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/jsu_fifo.sv -----
// Record queue between the front end and the output stage.
`default_nettype none

module jsu_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  jsu_pkg::rec_t      wr_rec,
	input  wire logic          pop,
	output jsu_pkg::rec_t      rd_rec,
	output logic               empty,
	output logic               full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	jsu_pkg::rec_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_rec = mem_q[rd_ptr_q];
	assign empty  = (count_q == '0);
	assign full   = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != CNT_W'(DEPTH))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/jsu_back.sv -----
// Output stage: sends the results of each queued record one per cycle while result_stall is low.
`default_nettype none

module jsu_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  jsu_pkg::rec_t      head,
	input  wire logic          empty,
	output logic               pop,
	output logic               result_valid,
	input  wire logic          result_stall,
	output logic [7:0]         out_byte,
	output logic [1:0]         kind,
	output logic               last
);

	logic [jsu_pkg::RES_IDX_W-1:0] idx_q;
	logic                          valid_q;
	jsu_pkg::ent_t                 ent_q;
	logic                          load;

	assign load = !empty && (!valid_q || !result_stall);
	assign pop  = load && (idx_q == head.cnt - 3'd1);

	always_ff @(posedge clk) begin
		if (load)
			ent_q <= head.ent[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= pop ? '0 : idx_q + 3'd1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = valid_q;
	assign out_byte     = ent_q.data;
	assign kind         = ent_q.kind;
	assign last         = ent_q.last;

`ifndef NO_ASSERTIONS
	a_idx_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> idx_q < head.cnt)
		else $error("result index beyond record");
`endif

endmodule

`default_nettype wire

// ----- rtl/json_string_unescape_utf8.sv -----
// Top level of the JSON string unescape to UTF-8 decoder.
//
// Input channel: byte_valid / byte_stall carry in_byte and token_end, one raw byte
// of a string token per transfer; token_end marks the token's final byte.
// Output channel: result_valid / result_stall carry out_byte, kind and last.
// Kind 0 is a decoded byte, kind 1 a clean token end, kind 2 a token end with a
// decode error; every token closes with exactly one end result with last set.
// Config channel: cfg_valid / cfg_ready write cfg_data, the BOM strip enable (1 drops
// a leading EF BB BF); cfg_ready is always high. Write it only while the block is idle.
// With an empty queue, a byte's first result is written into the queue and then into the
// output register before result_valid rises; it transfers once result_stall is low.
// Throughput: one byte per cycle while result_stall is low and each byte yields at most
// one result; a byte that yields n results (up to 7) holds the output stage for all n.
// A queue of DEPTH records absorbs such bursts; byte_stall rises when it is full.
// When result_stall is high, the presented result holds and the queue fills.
// Reset clears all token state, empties the queue and sets the strip enable to 1.
`default_nettype none

module json_string_unescape_utf8 #(
	parameter int DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       token_end,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [7:0]      out_byte,
	output logic [1:0]      kind,
	output logic            last,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data
);

	jsu_pkg::rec_t wr_rec, head;
	logic          accept, push, pop, empty, full;

	assign cfg_ready  = 1'b1;
	assign byte_stall = full;
	assign accept     = byte_valid && !full;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (in_byte),
		.token_end (token_end),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_strip (cfg_data),
		.rec       (wr_rec),
		.push      (push)
	);

	jsu_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.rd_rec (head),
		.empty  (empty),
		.full   (full)
	);

	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.kind         (kind),
		.last         (last)
	);

endmodule

`default_nettype wire
